>>> hdl/pmdl_pkg.sv
// Shared types and constants for the partition merge block with dense group labels.
package pmdl_pkg;

  localparam int unsigned MAX_MEMBERS_DEF = 64;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned LBL_W           = 6;
  localparam int unsigned CNT_W           = 7;
  localparam int unsigned MASK_W          = 64;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLY  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LBL_W-1:0]  member_a;
    logic [LBL_W-1:0]  member_b;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LBL_W-1:0]  new_member;
    logic [LBL_W-1:0]  member_group;
    logic [MASK_W-1:0] ally_mask;
    logic [CNT_W-1:0]  group_count;
    logic [CNT_W-1:0]  member_count;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [LBL_W-1:0] a;
    logic [LBL_W-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

>>> hdl/pmdl_front.sv
// Front end: accepts items, decodes the mode and queues commands for the back end.
module pmdl_front import pmdl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_item_t item_i,
  output q_head_t  head_o,
  input  logic     pop_i
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  cmd_t              cmd_in;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // Mode 3 carries no meaning of its own and runs as a query.
  always_comb begin
    cmd_in.a = item_i.member_a;
    cmd_in.b = item_i.member_b;
    unique case (item_i.mode) inside
      MODE_ADD:               cmd_in.op = OP_ADD;
      MODE_ALLY:              cmd_in.op = OP_ALLY;
      MODE_QUERY, MODE_SPARE: cmd_in.op = OP_QUERY;
    endcase
  end

  assign busy = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = entry_q[rd_q];

  always_comb begin
    wr_d  = push ? ptr_next(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_next(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= cmd_in;
    end
  end

endmodule

>>> hdl/pmdl_back.sv
// Back end: label memory, relabel sweep and result assembly.
module pmdl_back import pmdl_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = MAX_MEMBERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_head_t   head_i,
  output logic      pop_o,
  output logic      result_valid_o,
  output out_item_t result_o
);

  localparam int unsigned IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_MEMBERS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  mu_q, mu_d;
  logic [CNT_W-1:0]  gu_q, gu_d;

  op_e               op_q, op_d;
  logic [LBL_W-1:0]  a_q, a_d;
  logic [LBL_W-1:0]  b_q, b_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [LBL_W-1:0]  new_q, new_d;
  logic              a_ok_q, a_ok_d;
  logic              merge_q, merge_d;
  logic [LBL_W-1:0]  lo_q, lo_d;
  logic [LBL_W-1:0]  hi_q, hi_d;
  logic [LBL_W-1:0]  grp_q, grp_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [CNT_W-1:0]  rd_q, rd_d;
  logic              pv_q, pv_d;
  logic [LBL_W-1:0]  pi_q, pi_d;

  logic [LBL_W-1:0]  mem [MAX_MEMBERS];
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [LBL_W-1:0]  wdata;
  logic [IDX_W-1:0]  raddr_a, raddr_b;
  logic [LBL_W-1:0]  rdata_a_q, rdata_b_q;

  // Merged-away label takes the low label; labels above it close the gap.
  function automatic logic [LBL_W-1:0] remap(input logic [LBL_W-1:0] d,
                                             input logic [LBL_W-1:0] lo,
                                             input logic [LBL_W-1:0] hi);
    logic [LBL_W-1:0] r;
    r = d;
    if (d == hi) begin
      r = lo;
    end else if (d > hi) begin
      r = d - LBL_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    logic             a_ok, b_ok, issue;
    logic [LBL_W-1:0] lo_c, hi_c, nd;

    state_d  = state_q;
    mu_d     = mu_q;
    gu_d     = gu_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    status_d = status_q;
    new_d    = new_q;
    a_ok_d   = a_ok_q;
    merge_d  = merge_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    grp_d    = grp_q;
    mask_d   = mask_q;
    rd_d     = rd_q;
    pv_d     = 1'b0;
    pi_d     = pi_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr_a  = '0;
    raddr_b  = '0;
    a_ok     = (CNT_W'(a_q) < mu_q);
    b_ok     = (CNT_W'(b_q) < mu_q);
    lo_c     = (rdata_a_q < rdata_b_q) ? rdata_a_q : rdata_b_q;
    hi_c     = (rdata_a_q < rdata_b_q) ? rdata_b_q : rdata_a_q;
    issue    = (rd_q < mu_q);
    nd       = merge_q ? remap(rdata_a_q, lo_q, hi_q) : rdata_a_q;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          op_d     = head_i.cmd.op;
          a_d      = head_i.cmd.a;
          b_d      = head_i.cmd.b;
          status_d = STAT_OK;
          new_d    = '0;
          merge_d  = 1'b0;
          if (head_i.cmd.op == OP_ADD) begin
            if (mu_q >= CAP) begin
              status_d = STAT_FULL;
            end else begin
              // New member opens a group of its own.
              we    = 1'b1;
              waddr = mu_q[IDX_W-1:0];
              wdata = gu_q[LBL_W-1:0];
              new_d = mu_q[LBL_W-1:0];
              mu_d  = mu_q + CNT_W'(1);
              gu_d  = gu_q + CNT_W'(1);
            end
          end
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        raddr_a = a_q[IDX_W-1:0];
        raddr_b = b_q[IDX_W-1:0];
        state_d = S_EVAL;
      end
      S_EVAL: begin
        a_ok_d = a_ok;
        grp_d  = a_ok ? rdata_a_q : '0;
        if (op_q == OP_ALLY) begin
          if (!(a_ok && b_ok)) begin
            status_d = STAT_MISSING;
          end else if (rdata_a_q != rdata_b_q) begin
            merge_d = 1'b1;
            lo_d    = lo_c;
            hi_d    = hi_c;
            grp_d   = remap(rdata_a_q, lo_c, hi_c);
            if (gu_q != '0) begin
              gu_d = gu_q - CNT_W'(1);
            end
          end
        end else if (op_q == OP_QUERY && !a_ok) begin
          status_d = STAT_MISSING;
        end
        mask_d  = '0;
        rd_d    = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        // Read one entry per cycle; relabel and match it in the following cycle.
        if (issue) begin
          raddr_a = rd_q[IDX_W-1:0];
          rd_d    = rd_q + CNT_W'(1);
          pv_d    = 1'b1;
          pi_d    = rd_q[LBL_W-1:0];
        end
        if (pv_q) begin
          if (merge_q) begin
            we    = 1'b1;
            waddr = pi_q[IDX_W-1:0];
            wdata = nd;
          end
          if (a_ok_q && pi_q != a_q && nd == grp_q) begin
            mask_d[pi_q] = 1'b1;
          end
        end
        if (!issue && !pv_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mu_q    <= '0;
      gu_q    <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mu_q    <= mu_d;
      gu_q    <= gu_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    status_q <= status_d;
    new_q    <= new_d;
    a_ok_q   <= a_ok_d;
    merge_q  <= merge_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    grp_q    <= grp_d;
    mask_q   <= mask_d;
    rd_q     <= rd_d;
    pi_q     <= pi_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_q <= mem[raddr_a];
    rdata_b_q <= mem[raddr_b];
  end

  assign result_valid_o         = (state_q == S_DONE);
  assign result_o.status        = status_q;
  assign result_o.new_member    = new_q;
  assign result_o.member_group  = grp_q;
  assign result_o.ally_mask     = mask_q;
  assign result_o.group_count   = gu_q;
  assign result_o.member_count  = mu_q;

endmodule

>>> hdl/partition_merge_dense_labels_top.sv
// Top level of the partition merge block with dense group labels.
// Each item runs through the back end in steps: dispatch, label lookup, evaluate, a sweep
// over the table that reads one entry per cycle and then drains the read pipeline, and
// the result; an empty table gives the shortest sweep. The sweep uses the first of the
// label memory's two read ports and sets how long an item takes. A two-entry command
// queue sits in front:
// busy rises only when it is full, so up to two items may be taken while one is being
// worked. Each result is shown for exactly one cycle with result_valid_o high; the
// receiver cannot stall, so it must take the result in that cycle. After reset the
// table is empty and the block is ready at once.
module partition_merge_dense_labels_top import pmdl_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = MAX_MEMBERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      result_valid_o,
  output out_item_t result_o
);

  q_head_t head;
  logic    pop;

  pmdl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .head_o (head),
    .pop_i  (pop)
  );

  pmdl_back #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

>>> hdl/pmdl_checker.sv
// Port-level checks for the partition merge block, bound to the top level.
module pmdl_checker import pmdl_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = MAX_MEMBERS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      result_valid_o,
  input out_item_t result_o
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_MEMBERS);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.member_count <= CAP &&
                        result_o.group_count <= result_o.member_count))
    else $error("member or group count out of range");

  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((result_o.group_count == '0) == (result_o.member_count == '0)))
    else $error("group count and member count disagree on an empty table");

  a_mask_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((result_o.ally_mask >> result_o.member_count) == '0))
    else $error("ally mask names a member outside the table");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

endmodule

bind partition_merge_dense_labels_top pmdl_checker #(
  .MAX_MEMBERS (MAX_MEMBERS)
) u_pmdl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

>>> dv/tb_partition_merge_dense_labels_top.sv
// Testbench for partition_merge_dense_labels_top: queued commands against a label-table predictor.
`timescale 1ns / 100ps

module tb_partition_merge_dense_labels_top;
  import pmdl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned TAIL_CYCLES  = MAX_MEMBERS_DEF + 16;

  typedef struct {
    in_item_t cmd;
    bit       drain_first;
  } pending_cmd_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      result_valid_o;
  out_item_t result_o;

  // predictor state
  logic [LBL_W-1:0] label_of [MAX_MEMBERS_DEF];
  logic [CNT_W-1:0] member_total;
  logic [CNT_W-1:0] group_total;

  pending_cmd_t pending_cmds[$];
  out_item_t    awaited_results[$];
  int unsigned  queued_count;
  int unsigned  accepted_count;
  int unsigned  fail_count;
  int unsigned  cycle_count;
  int unsigned  idle_left;
  int unsigned  gen_members;

  partition_merge_dense_labels_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one command to the label table and return the result it should give.
  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t        res;
    logic [LBL_W-1:0] ga;
    logic [LBL_W-1:0] gb;
    logic [LBL_W-1:0] lo;
    logic [LBL_W-1:0] hi;
    int unsigned      a;
    int unsigned      b;
    res = '0;
    a = cmd.member_a;
    b = cmd.member_b;
    case (cmd.mode)
      MODE_ADD: begin
        if (member_total >= MAX_MEMBERS_DEF) begin
          res.status = STAT_FULL;
        end else begin
          res.new_member = member_total[LBL_W-1:0];
          label_of[member_total] = group_total[LBL_W-1:0];
          member_total = member_total + 1'b1;
          group_total = group_total + 1'b1;
        end
      end
      MODE_ALLY: begin
        if (a >= member_total || b >= member_total) begin
          res.status = STAT_MISSING;
        end else begin
          ga = label_of[a];
          gb = label_of[b];
          if (ga != gb) begin
            lo = (ga < gb) ? ga : gb;
            hi = (ga < gb) ? gb : ga;
            // fold the group with the higher label into the lower and close the gap above it
            for (int i = 0; i < member_total; i++) begin
              if (label_of[i] == hi) label_of[i] = lo;
              else if (label_of[i] > hi) label_of[i] = label_of[i] - 1'b1;
            end
            if (group_total > 0) group_total = group_total - 1'b1;
          end
        end
      end
      default: begin
        if (a >= member_total) res.status = STAT_MISSING;
      end
    endcase
    if (a < member_total) begin
      res.member_group = label_of[a];
      for (int i = 0; i < member_total; i++) begin
        if (i != a && label_of[i] == label_of[a]) res.ally_mask[i] = 1'b1;
      end
    end
    res.group_count = group_total;
    res.member_count = member_total;
    return res;
  endfunction

  // Queue a command and track how many members the table will hold.
  function automatic void queue_cmd(logic [MODE_W-1:0] mode, int unsigned a, int unsigned b,
                                    bit drain_first);
    pending_cmd_t p;
    p.cmd.mode = mode;
    p.cmd.member_a = a[LBL_W-1:0];
    p.cmd.member_b = b[LBL_W-1:0];
    p.drain_first = drain_first;
    pending_cmds.push_back(p);
    queued_count++;
    if (mode == MODE_ADD && gen_members < MAX_MEMBERS_DEF) gen_members++;
  endfunction

  // Mostly a present member, now and then any index.
  function automatic int unsigned pick_member();
    if (gen_members > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, gen_members - 1);
    return $urandom_range(0, 63);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      idle_left = 0;
    end else if (start && busy) begin
      // hold the item until the block takes it
    end else begin
      if (start) begin
        awaited_results.push_back(apply_command(item_i));
        accepted_count++;
        idle_left = $urandom_range(0, 3);
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].drain_first && awaited_results.size() != 0) begin
        start <= 1'b0;
      end else begin
        item_i <= pending_cmds[0].cmd;
        pending_cmds.delete(0);
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && result_valid_o) begin
      if (awaited_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_o.status);
          fail_count++;
        end
        if (result_o.new_member !== want.new_member) begin
          $error("new_member: expected %0d, got %0d", want.new_member, result_o.new_member);
          fail_count++;
        end
        if (result_o.member_group !== want.member_group) begin
          $error("member_group: expected %0d, got %0d", want.member_group,
                 result_o.member_group);
          fail_count++;
        end
        if (result_o.ally_mask !== want.ally_mask) begin
          $error("ally_mask: expected %h, got %h", want.ally_mask, result_o.ally_mask);
          fail_count++;
        end
        if (result_o.group_count !== want.group_count) begin
          $error("group_count: expected %0d, got %0d", want.group_count, result_o.group_count);
          fail_count++;
        end
        if (result_o.member_count !== want.member_count) begin
          $error("member_count: expected %0d, got %0d", want.member_count,
                 result_o.member_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL partition_merge_dense_labels_top");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    member_total = '0;
    group_total = '0;
    queued_count = 0;
    accepted_count = 0;
    fail_count = 0;
    cycle_count = 0;
    gen_members = 0;

    // directed: empty table, first adds, merges, missing indexes, spare mode
    queue_cmd(MODE_QUERY, 0, 63, 1'b0);
    queue_cmd(MODE_SPARE, 0, 0, 1'b0);
    queue_cmd(MODE_ALLY, 0, 0, 1'b0);
    queue_cmd(MODE_ADD, 63, 63, 1'b0);
    queue_cmd(MODE_ADD, 0, 42, 1'b0);
    queue_cmd(MODE_ALLY, 0, 1, 1'b0);
    queue_cmd(MODE_ALLY, 1, 0, 1'b0);
    queue_cmd(MODE_ADD, 2, 21, 1'b0);
    queue_cmd(MODE_ADD, 63, 0, 1'b0);
    queue_cmd(MODE_ADD, 4, 63, 1'b0);
    queue_cmd(MODE_ALLY, 4, 2, 1'b0);
    queue_cmd(MODE_ALLY, 3, 0, 1'b0);
    queue_cmd(MODE_ALLY, 2, 2, 1'b0);
    queue_cmd(MODE_QUERY, 63, 0, 1'b0);
    queue_cmd(MODE_ALLY, 0, 63, 1'b0);
    queue_cmd(MODE_ALLY, 63, 0, 1'b0);
    queue_cmd(MODE_ALLY, 5, 5, 1'b0);
    queue_cmd(MODE_QUERY, 2, 45, 1'b0);
    queue_cmd(MODE_SPARE, 4, 18, 1'b0);
    queue_cmd(MODE_QUERY, 4, 0, 1'b0);

    // random: slow growth so the table fills about halfway through
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        queue_cmd(MODE_ADD, pick_member(), $urandom_range(0, 63), n % 400 == 0);
      end else if (r < 40) begin
        queue_cmd(MODE_ALLY, pick_member(), pick_member(), n % 400 == 0);
      end else if (r < 95) begin
        queue_cmd(MODE_QUERY, pick_member(), $urandom_range(0, 63), n % 400 == 0);
      end else begin
        queue_cmd(MODE_SPARE, pick_member(), $urandom_range(0, 63), n % 400 == 0);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count != queued_count) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS partition_merge_dense_labels_top");
    end else begin
      $display("FAIL partition_merge_dense_labels_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pmdl_pkg.sv
hdl/pmdl_front.sv
hdl/pmdl_back.sv
hdl/partition_merge_dense_labels_top.sv
hdl/pmdl_checker.sv
dv/tb_partition_merge_dense_labels_top.sv
